[rtl/water_ripple_grid_step_macros.svh]
// ----------------------------------------------------------------------------
// water ripple grid step: assertion macros
// Concurrent assertion wrappers used by the top rtl file.
// ----------------------------------------------------------------------------
`ifndef WATER_RIPPLE_GRID_STEP_MACROS_SVH
`define WATER_RIPPLE_GRID_STEP_MACROS_SVH

`ifndef ASSERT_OFF
// checked while out of reset
`define WRG_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("wrg assertion failed");
// checked during reset too
`define WRG_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("wrg assertion failed");
`else
`define WRG_ASSERT(lbl, clk, rst_n, prop)
`define WRG_ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

[rtl/wrg_pkg.sv]
// ----------------------------------------------------------------------------
// wrg_pkg
// Types, constants and helpers of the water ripple grid step block.
// ----------------------------------------------------------------------------
`default_nettype none

package wrg_pkg;

  localparam int unsigned GridWidthDef  = 128;
  localparam int unsigned GridHeightDef = 128;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;

  // restoring divider: numerator covers |neighbour sum| and 150 * val
  localparam int unsigned DivNumW = 19;
  localparam int unsigned DivDenW = 8;

  localparam int unsigned MulAW = 29;
  localparam int unsigned MulBW = 17;
  localparam int unsigned MulPW = MulAW + MulBW;

  localparam logic [9:0]  StiffRst = 10'd150;
  localparam logic [15:0] DampRst  = 16'd8520;
  localparam logic [11:0] AmpRst   = 12'd1638;
  localparam logic [7:0]  SpanRst  = 8'd160;
  localparam logic [7:0]  BlueFull = 8'd255;
  localparam logic [7:0]  BlueGain = 8'd150;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_STIFFNESS = 3'd0,
    CFG_DAMPING   = 3'd1,
    CFG_AMPLITUDE = 3'd2,
    CFG_SPAN      = 3'd3
  } cfg_idx_e;

  typedef struct packed {
    logic        is_land;
    logic        raft_here;
    logic        disturb_here;
    logic [15:0] time_step;
  } in_t;

  typedef struct packed {
    logic signed [15:0] height;
    logic [7:0]         red;
    logic [7:0]         green;
    logic [7:0]         blue;
    logic               last_of_frame;
  } out_t;

  typedef struct packed {
    logic               done;
    logic [DivNumW-1:0] quot;
    logic               rem_nz;
  } div_res_t;

  typedef enum logic [4:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_DRAIN,
    ST_MEAN,
    ST_MEAN_WAIT,
    ST_M1,
    ST_M2,
    ST_M3,
    ST_M4,
    ST_M5,
    ST_M6,
    ST_M7,
    ST_COL1,
    ST_COL2,
    ST_COL3,
    ST_BLUE,
    ST_BLUE_WAIT,
    ST_FIN
  } state_e;

  function automatic logic signed [15:0] sat16(input logic signed [31:0] x);
    logic signed [15:0] r;
    if (x > 32'sd32767) r = 16'sh7fff;
    else if (x < -32'sd32768) r = 16'sh8000;
    else r = x[15:0];
    return r;
  endfunction

endpackage

`default_nettype wire

[rtl/water_ripple_grid_step.sv]
// ----------------------------------------------------------------------------
// water_ripple_grid_step
// One water grid cell per request, raster order, two alternating frame stores.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel takes one cell request (land, raft, disturbance flags and
//   the frame time step) when in_valid_i is high and in_stall_o is low. The
//   output channel offers the new height and colour on out_valid_o and holds
//   it while out_stall_i is high. Registers are written through cfg_we_i,
//   cfg_idx_i and cfg_wdata_i; the user must write them only while no
//   request is in flight, as the block itself does not enforce it. A water
//   cell goes through nine serial frame store reads, one serial divider
//   pass for the neighbour mean, seven steps of the shared multiplier and
//   a second divider pass for the blue channel unless the span is zero.
//   A forced cell skips the reads, the mean and the seven multiplier
//   steps. One cell is in work at a time. The result sits in an output
//   register, so a stalled receiver holds up the next cell only when it
//   finishes before the old result was taken. After reset both frame stores
//   are swept to zero, one entry a cycle, with in_stall_o high meanwhile.
// ----------------------------------------------------------------------------
`default_nettype none

module water_ripple_grid_step #(
  parameter int unsigned GRID_WIDTH  = wrg_pkg::GridWidthDef,
  parameter int unsigned GRID_HEIGHT = wrg_pkg::GridHeightDef
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire wrg_pkg::in_t                  in_data_i,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output wrg_pkg::out_t                      out_data_o,
  input  wire logic                          cfg_we_i,
  input  wire logic [wrg_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  wire logic [wrg_pkg::CfgDataW-1:0]  cfg_wdata_i
);
  import wrg_pkg::*;

  `include "water_ripple_grid_step_macros.svh"

  localparam int unsigned Cells = GRID_WIDTH * GRID_HEIGHT;
  localparam int unsigned AddrW = $clog2(Cells);
  localparam int unsigned ColW  = $clog2(GRID_WIDTH);
  localparam int unsigned RowW  = $clog2(GRID_HEIGHT);

  state_e state_q, state_d;

  logic [9:0]  stiff_q;
  logic [15:0] damp_q;
  logic [11:0] amp_q;
  logic [7:0]  span_q;

  logic [AddrW-1:0] clr_q, clr_d;
  logic [AddrW-1:0] idx_q, idx_d;
  logic [ColW-1:0]  col_q, col_d;
  logic [RowW-1:0]  row_q, row_d;
  logic             buf_q, buf_d;
  logic [3:0]       k_q, k_d;
  logic             rd_vld_q, rd_vld_d;
  logic             rd_ctr_q, rd_ctr_d;
  logic             out_valid_q, out_valid_d;

  in_t                     cell_q, cell_d;
  logic signed [19:0]      sum_q, sum_d;
  logic [3:0]              cnt_q, cnt_d;
  logic signed [15:0]      h0_q, h0_d, v0_q, v0_d;
  logic signed [16:0]      mean_q, mean_d;
  logic signed [MulPW-1:0] prod_q;
  logic signed [MulAW-1:0] t1_q, t1_d, force_q, force_d;
  logic signed [15:0]      h_q, h_d, v_q, v_d;
  logic [7:0]              val_q, val_d;
  logic [7:0]              blue_q, blue_d;
  out_t                    out_q, out_d;

  logic signed [MulAW-1:0] mul_a;
  logic signed [MulBW-1:0] mul_b;

  logic                 div_start;
  logic [DivNumW-1:0]   div_num;
  logic [DivDenW-1:0]   div_den;
  logic                 div_busy;
  div_res_t             div_res;

  logic                 we_a, we_b;
  logic [AddrW-1:0]     waddr, raddr;
  logic [31:0]          wdata, rdata_a, rdata_b, rdata;

  logic                 in_acc, out_load, last_cell;
  logic                 nb_ok;
  logic signed [1:0]    nb_dx, nb_dy;
  logic [AddrW-1:0]     nb_addr;
  logic signed [31:0]   wide;
  logic signed [24:0]   col_sum;
  logic signed [11:0]   col_val;
  logic [7:0]           span_diff;
  logic [18:0]          sum_mag;

  assign in_stall_o  = (state_q != ST_IDLE);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign rdata       = buf_q ? rdata_a : rdata_b;
  assign last_cell   = (col_q == ColW'(GRID_WIDTH - 1)) && (row_q == RowW'(GRID_HEIGHT - 1));
  assign sum_mag     = sum_q[19] ? 19'(-sum_q) : sum_q[18:0];

  // neighbour offsets, k = 0..8 over the 3x3 window, center at k = 4
  always_comb begin
    nb_dx = 2'sd0;
    nb_dy = 2'sd0;
    unique case (k_q)
      4'd0: begin nb_dy = -2'sd1; nb_dx = -2'sd1; end
      4'd1: begin nb_dy = -2'sd1; nb_dx =  2'sd0; end
      4'd2: begin nb_dy = -2'sd1; nb_dx =  2'sd1; end
      4'd3: begin nb_dy =  2'sd0; nb_dx = -2'sd1; end
      4'd4: begin nb_dy =  2'sd0; nb_dx =  2'sd0; end
      4'd5: begin nb_dy =  2'sd0; nb_dx =  2'sd1; end
      4'd6: begin nb_dy =  2'sd1; nb_dx = -2'sd1; end
      4'd7: begin nb_dy =  2'sd1; nb_dx =  2'sd0; end
      4'd8: begin nb_dy =  2'sd1; nb_dx =  2'sd1; end
      default: begin nb_dy = 2'sd0; nb_dx = 2'sd0; end
    endcase
    nb_ok = !((nb_dx == -2'sd1) && (col_q == '0)) &&
            !((nb_dx ==  2'sd1) && (col_q == ColW'(GRID_WIDTH - 1))) &&
            !((nb_dy == -2'sd1) && (row_q == '0)) &&
            !((nb_dy ==  2'sd1) && (row_q == RowW'(GRID_HEIGHT - 1)));
    nb_addr = idx_q;
    if (nb_dy == -2'sd1) nb_addr = nb_addr - AddrW'(GRID_WIDTH);
    if (nb_dy ==  2'sd1) nb_addr = nb_addr + AddrW'(GRID_WIDTH);
    if (nb_dx == -2'sd1) nb_addr = nb_addr - 1'b1;
    if (nb_dx ==  2'sd1) nb_addr = nb_addr + 1'b1;
  end

  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    idx_d       = idx_q;
    col_d       = col_q;
    row_d       = row_q;
    buf_d       = buf_q;
    k_d         = k_q;
    rd_vld_d    = 1'b0;
    rd_ctr_d    = 1'b0;
    out_valid_d = out_valid_q;
    cell_d      = cell_q;
    sum_d       = sum_q;
    cnt_d       = cnt_q;
    h0_d        = h0_q;
    v0_d        = v0_q;
    mean_d      = mean_q;
    t1_d        = t1_q;
    force_d     = force_q;
    h_d         = h_q;
    v_d         = v_q;
    val_d       = val_q;
    blue_d      = blue_q;
    out_d       = out_q;
    mul_a       = '0;
    mul_b       = '0;
    div_start   = 1'b0;
    div_num     = '0;
    div_den     = '0;
    we_a        = 1'b0;
    we_b        = 1'b0;
    waddr       = idx_q;
    wdata       = {v_q, h_q};
    raddr       = nb_addr;
    out_load    = 1'b0;
    wide        = '0;
    col_sum     = '0;
    col_val     = '0;
    span_diff   = '0;

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    // returning read data from the previous cycle
    if (rd_vld_q) begin
      if (rd_ctr_q) begin
        h0_d = rdata[15:0];
        v0_d = rdata[31:16];
      end else begin
        sum_d = sum_q + 20'(signed'(rdata[15:0]));
        cnt_d = cnt_q + 1'b1;
      end
    end

    unique case (state_q)
      ST_CLEAR: begin
        we_a  = 1'b1;
        we_b  = 1'b1;
        waddr = clr_q;
        wdata = '0;
        clr_d = clr_q + 1'b1;
        if (clr_q == AddrW'(Cells - 1)) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_acc) begin
          cell_d = in_data_i;
          sum_d  = '0;
          cnt_d  = '0;
          k_d    = '0;
          v_d    = '0;
          if (in_data_i.raft_here) begin
            h_d     = -16'(signed'({4'b0, amp_q}));
            state_d = ST_COL1;
          end else if (in_data_i.is_land) begin
            h_d     = '0;
            state_d = ST_COL1;
          end else if (in_data_i.disturb_here) begin
            h_d     = 16'(signed'({4'b0, amp_q}));
            state_d = ST_COL1;
          end else begin
            state_d = ST_READ;
          end
        end
      end
      ST_READ: begin
        rd_vld_d = nb_ok;
        rd_ctr_d = (k_q == 4'd4);
        k_d      = k_q + 1'b1;
        if (k_q == 4'd8) state_d = ST_DRAIN;
      end
      ST_DRAIN: state_d = ST_MEAN;
      ST_MEAN: begin
        div_start = 1'b1;
        div_num   = sum_mag;
        div_den   = {4'b0, cnt_q};
        state_d   = ST_MEAN_WAIT;
      end
      ST_MEAN_WAIT: begin
        if (div_res.done) begin
          // floor division for a negative sum
          if (sum_q[19]) begin
            mean_d = -17'(signed'({1'b0, div_res.quot[16:0]}))
                     - 17'(signed'({16'b0, div_res.rem_nz}));
          end else begin
            mean_d = 17'(signed'({1'b0, div_res.quot[15:0]}));
          end
          state_d = ST_M1;
        end
      end
      ST_M1: begin
        mul_a   = MulAW'(h0_q) - MulAW'(mean_q);
        mul_b   = MulBW'(signed'({1'b0, stiff_q}));
        state_d = ST_M2;
      end
      ST_M2: begin
        t1_d    = prod_q[MulAW-1:0];
        mul_a   = MulAW'(v0_q);
        mul_b   = signed'({1'b0, damp_q});
        state_d = ST_M3;
      end
      ST_M3: begin
        force_d = -t1_q - prod_q[MulAW+15:16];
        state_d = ST_M4;
      end
      ST_M4: begin
        mul_a   = force_q;
        mul_b   = signed'({1'b0, cell_q.time_step});
        state_d = ST_M5;
      end
      ST_M5: begin
        wide    = 32'(v0_q) + 32'(signed'(prod_q[MulPW-1:16]));
        v_d     = sat16(wide);
        state_d = ST_M6;
      end
      ST_M6: begin
        mul_a   = MulAW'(v_q);
        mul_b   = signed'({1'b0, cell_q.time_step});
        state_d = ST_M7;
      end
      ST_M7: begin
        wide    = 32'(h0_q) + 32'(signed'(prod_q[MulPW-1:16]));
        h_d     = sat16(wide);
        state_d = ST_COL1;
      end
      ST_COL1: begin
        we_a    = !buf_q;
        we_b    = buf_q;
        mul_a   = MulAW'(h_q);
        mul_b   = MulBW'(signed'({1'b0, span_q}));
        state_d = ST_COL2;
      end
      ST_COL2: begin
        col_sum = 25'(signed'({1'b0, span_q[7:1], 13'b0})) + prod_q[24:0];
        col_val = col_sum[24:13];
        if (col_val < 12'sd0) val_d = '0;
        else if (col_val > 12'(signed'({1'b0, span_q}))) val_d = span_q;
        else val_d = col_val[7:0];
        state_d = ST_COL3;
      end
      ST_COL3: begin
        mul_a   = MulAW'(signed'({1'b0, val_q}));
        mul_b   = MulBW'(signed'({1'b0, BlueGain}));
        state_d = ST_BLUE;
      end
      ST_BLUE: begin
        if (span_q == '0) begin
          blue_d  = BlueFull;
          state_d = ST_FIN;
        end else begin
          div_start = 1'b1;
          div_num   = prod_q[DivNumW-1:0];
          div_den   = span_q;
          state_d   = ST_BLUE_WAIT;
        end
      end
      ST_BLUE_WAIT: begin
        if (div_res.done) begin
          blue_d  = BlueFull - div_res.quot[7:0];
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        if (!out_valid_q || !out_stall_i) begin
          out_load            = 1'b1;
          span_diff           = span_q - val_q;
          out_d.height        = h_q;
          out_d.red           = {1'b0, span_diff[7:1]};
          out_d.green         = span_diff;
          out_d.blue          = blue_q;
          out_d.last_of_frame = last_cell;
          out_valid_d         = 1'b1;
          if (last_cell) begin
            col_d = '0;
            row_d = '0;
            idx_d = '0;
            buf_d = !buf_q;
          end else if (col_q == ColW'(GRID_WIDTH - 1)) begin
            col_d = '0;
            row_d = row_q + 1'b1;
            idx_d = idx_q + 1'b1;
          end else begin
            col_d = col_q + 1'b1;
            idx_d = idx_q + 1'b1;
          end
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      idx_q       <= '0;
      col_q       <= '0;
      row_q       <= '0;
      buf_q       <= 1'b0;
      k_q         <= '0;
      rd_vld_q    <= 1'b0;
      rd_ctr_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      idx_q       <= idx_d;
      col_q       <= col_d;
      row_q       <= row_d;
      buf_q       <= buf_d;
      k_q         <= k_d;
      rd_vld_q    <= rd_vld_d;
      rd_ctr_q    <= rd_ctr_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stiff_q <= StiffRst;
      damp_q  <= DampRst;
      amp_q   <= AmpRst;
      span_q  <= SpanRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_STIFFNESS: stiff_q <= cfg_wdata_i[9:0];
        CFG_DAMPING:   damp_q  <= cfg_wdata_i;
        CFG_AMPLITUDE: amp_q   <= cfg_wdata_i[11:0];
        CFG_SPAN:      span_q  <= cfg_wdata_i[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    cell_q  <= cell_d;
    sum_q   <= sum_d;
    cnt_q   <= cnt_d;
    h0_q    <= h0_d;
    v0_q    <= v0_d;
    mean_q  <= mean_d;
    prod_q  <= mul_a * mul_b;
    t1_q    <= t1_d;
    force_q <= force_d;
    h_q     <= h_d;
    v_q     <= v_d;
    val_q   <= val_d;
    blue_q  <= blue_d;
    out_q   <= out_d;
  end

  wrg_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .busy_o  (div_busy),
    .res_o   (div_res)
  );

  wrg_ram #(.Width(32), .Depth(Cells)) u_store_a (
    .clk_i   (clk_i),
    .we_i    (we_a),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata_a)
  );

  wrg_ram #(.Width(32), .Depth(Cells)) u_store_b (
    .clk_i   (clk_i),
    .we_i    (we_b),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata_b)
  );

  `WRG_ASSERT(a_busy_after_req, clk_i, rst_ni, in_acc |=> in_stall_o)
  `WRG_ASSERT(a_div_free, clk_i, rst_ni, div_start |-> !div_busy)
  `WRG_ASSERT(a_out_slot_free, clk_i, rst_ni, out_load |-> (!out_valid_q || !out_stall_i))
  `WRG_ASSERT_ALWAYS(a_no_out_in_clear, clk_i, (state_q == ST_CLEAR) |-> !out_valid_q)

endmodule

`default_nettype wire

[rtl/wrg_ram.sv]
// ----------------------------------------------------------------------------
// wrg_ram
// Generic single write, single read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module wrg_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 16384
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]              rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

`default_nettype wire

[rtl/wrg_div.sv]
// ----------------------------------------------------------------------------
// wrg_div
// Serial restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module wrg_div (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start_i,
  input  wire logic [wrg_pkg::DivNumW-1:0]   num_i,
  input  wire logic [wrg_pkg::DivDenW-1:0]   den_i,
  output logic                               busy_o,
  output wrg_pkg::div_res_t                  res_o
);
  import wrg_pkg::*;

  localparam int unsigned CntW = $clog2(DivNumW + 1);

  logic [CntW-1:0]    cnt_q, cnt_d;
  logic               busy_q, busy_d;
  logic               done_q, done_d;
  logic [DivNumW-1:0] num_q, num_d;
  logic [DivNumW-1:0] quot_q, quot_d;
  logic [DivDenW-1:0] den_q, den_d;
  logic [DivDenW-1:0] rem_q, rem_d;
  logic [DivDenW:0]   trial;

  always_comb begin
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    num_d  = num_q;
    quot_d = quot_q;
    den_d  = den_q;
    rem_d  = rem_q;
    trial  = {rem_q, num_q[DivNumW-1]};
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CntW'(DivNumW);
      num_d  = num_i;
      den_d  = den_i;
      rem_d  = '0;
      quot_d = '0;
    end else if (busy_q) begin
      num_d = {num_q[DivNumW-2:0], 1'b0};
      if (trial >= {1'b0, den_q}) begin
        rem_d  = DivDenW'(trial - {1'b0, den_q});
        quot_d = {quot_q[DivNumW-2:0], 1'b1};
      end else begin
        rem_d  = trial[DivDenW-1:0];
        quot_d = {quot_q[DivNumW-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q  <= num_d;
    quot_q <= quot_d;
    den_q  <= den_d;
    rem_q  <= rem_d;
  end

  assign busy_o        = busy_q;
  assign res_o.done    = done_q;
  assign res_o.quot    = quot_q;
  assign res_o.rem_nz  = (rem_q != '0);

endmodule

`default_nettype wire

[bench/tb.sv]
// ----------------------------------------------------------------------------
// water ripple grid step testbench
// Drives cell requests in raster order and checks each result against its
// directed table row or a predictor that holds its own copy of both frame
// stores. A directed table comes first, then mostly water cells run under
// several register settings. Both sides idle and stall at random.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tb;
  import wrg_pkg::*;

  localparam int GridW = 128;
  localparam int GridH = 128;
  localparam int Cells = GridW * GridH;
  localparam int Settle = 80;
  localparam int CycleLimit = 4000000;
  localparam logic [CfgIdxW-1:0] CfgIdxUnused = 3'd7;

  typedef struct {
    in_t  req;
    bit   typed;
    out_t want;
  } dir_row_t;

  logic clk_i, rst_ni;
  logic in_valid_i, in_stall_o, out_valid_o, out_stall_i;
  in_t  in_data_i;
  out_t out_data_o;
  logic cfg_we_i;
  logic [CfgIdxW-1:0] cfg_idx_i;
  logic [CfgDataW-1:0] cfg_wdata_i;

  water_ripple_grid_step dut (.*);

  // predictor state
  logic [15:0] plane_h [2][Cells];
  logic [15:0] plane_v [2][Cells];
  bit          swap_sel;
  int          cur_col, cur_row;
  logic [9:0]  stiff_r;
  logic [15:0] damp_r;
  logic [11:0] amp_r;
  logic [7:0]  span_r;

  out_t   pending_q[$];
  int     err_cnt = 0;
  int     cycle_cnt = 0;
  bit     calm;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic longint clamp16(input longint x);
    if (x > 32767) return 32767;
    if (x < -32768) return -32768;
    return x;
  endfunction

  function automatic out_t ripple_next(input in_t c);
    int x, y, idx, nx, ny, cnt, src, dst;
    longint sum, mean, h0, v0, force_val, h, v, val, span;
    out_t r;
    x = cur_col;
    y = cur_row;
    idx = y * GridW + x;
    src = swap_sel ? 0 : 1;
    dst = swap_sel ? 1 : 0;
    if (c.raft_here) begin
      h = -longint'(amp_r);
      v = 0;
    end else if (c.is_land) begin
      h = 0;
      v = 0;
    end else if (c.disturb_here) begin
      h = longint'(amp_r);
      v = 0;
    end else begin
      sum = 0;
      cnt = 0;
      h0 = longint'($signed(plane_h[src][idx]));
      v0 = longint'($signed(plane_v[src][idx]));
      for (int dy = -1; dy <= 1; dy++)
        for (int dx = -1; dx <= 1; dx++) begin
          nx = x + dx;
          ny = y + dy;
          if ((dx != 0 || dy != 0) && nx >= 0 && nx < GridW && ny >= 0 && ny < GridH) begin
            sum += longint'($signed(plane_h[src][ny * GridW + nx]));
            cnt++;
          end
        end
      mean = sum / cnt;
      if (sum % cnt != 0 && sum < 0) mean--;
      force_val = -longint'(stiff_r) * (h0 - mean) - ((longint'(damp_r) * v0) >>> 16);
      v = clamp16(v0 + ((force_val * longint'(c.time_step)) >>> 16));
      h = clamp16(h0 + ((v * longint'(c.time_step)) >>> 16));
    end
    plane_h[dst][idx] = h[15:0];
    plane_v[dst][idx] = v[15:0];

    span = longint'(span_r);
    if (span == 0) val = 0;
    else begin
      val = ((span >>> 1) * 8192 + h * span) >>> 13;
      if (val > span) val = span;
      if (val < 0) val = 0;
    end
    r.height = h[15:0];
    r.red = 8'((span - val) / 2);
    r.green = 8'(span - val);
    r.blue = (span == 0) ? BlueFull : 8'(255 - (150 * val) / span);
    r.last_of_frame = (x == GridW - 1) && (y == GridH - 1);

    if (r.last_of_frame) begin
      cur_col = 0;
      cur_row = 0;
      swap_sel = ~swap_sel;
    end else if (x + 1 >= GridW) begin
      cur_col = 0;
      cur_row = y + 1;
    end else cur_col = x + 1;
    return r;
  endfunction

  task automatic report(input string what, input longint got, input longint want);
    $display("mismatch %s: got %0d expected %0d (cycle %0d)", what, got, want, cycle_cnt);
    err_cnt++;
  endtask

  // caller stands at a rising edge
  task automatic push_cell(input in_t c, input bit typed, input out_t want);
    out_t p;
    in_valid_i <= 1'b1;
    in_data_i  <= c;
    do @(posedge clk_i); while (in_stall_o);
    p = ripple_next(c);
    pending_q.push_back(typed ? want : p);
    if (!calm && $urandom_range(0, 99) < 20) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] d);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= d;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_STIFFNESS: stiff_r = d[9:0];
      CFG_DAMPING:   damp_r  = d;
      CFG_AMPLITUDE: amp_r   = d[11:0];
      CFG_SPAN:      span_r  = d[7:0];
      default: ;
    endcase
  endtask

  task automatic set_regs(input logic [15:0] s, input logic [15:0] d,
                          input logic [15:0] a, input logic [15:0] sp);
    in_valid_i <= 1'b0;
    wait (pending_q.size() == 0);
    repeat (Settle) @(posedge clk_i);
    write_reg(CFG_STIFFNESS, s);
    write_reg(CFG_DAMPING, d);
    write_reg(CFG_AMPLITUDE, a);
    write_reg(CFG_SPAN, sp);
    // unused index must leave every register alone
    write_reg(CfgIdxUnused, 16'($urandom));
  endtask

  function automatic in_t rand_cell(input int water_pct);
    in_t c;
    c.time_step = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 64)) : 16'($urandom);
    if ($urandom_range(0, 99) < water_pct) begin
      c.is_land = 1'b0;
      c.raft_here = 1'b0;
      c.disturb_here = 1'b0;
    end else begin
      c.is_land = 1'($urandom_range(0, 1));
      c.raft_here = 1'($urandom_range(0, 1));
      c.disturb_here = 1'($urandom_range(0, 1));
    end
    return c;
  endfunction

  // result side: random stall, compare on every handshake
  always @(posedge clk_i or negedge rst_ni) begin
    out_t w;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (pending_q.size() == 0) begin
          report("unexpected result", 1, 0);
        end else begin
          w = pending_q.pop_front();
          if (out_data_o.height !== w.height) report("height", out_data_o.height, w.height);
          if (out_data_o.red !== w.red) report("red", out_data_o.red, w.red);
          if (out_data_o.green !== w.green) report("green", out_data_o.green, w.green);
          if (out_data_o.blue !== w.blue) report("blue", out_data_o.blue, w.blue);
          if (out_data_o.last_of_frame !== w.last_of_frame)
            report("last_of_frame", out_data_o.last_of_frame, w.last_of_frame);
        end
      end
      out_stall_i <= calm ? 1'b0 : ($urandom_range(0, 99) < 20);
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CycleLimit) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    dir_row_t rows[$];
    out_t zero_o, raft_o, dist_o, none_o;
    logic [15:0] cfg_sets[5][4];

    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    in_data_i = '0;
    cfg_we_i = 1'b0;
    cfg_idx_i = CFG_STIFFNESS;
    cfg_wdata_i = '0;
    calm = 1'b0;
    swap_sel = 1'b0;
    cur_col = 0;
    cur_row = 0;
    stiff_r = StiffRst;
    damp_r = DampRst;
    amp_r = AmpRst;
    span_r = SpanRst;
    for (int i = 0; i < Cells; i++) begin
      plane_h[0][i] = '0; plane_h[1][i] = '0;
      plane_v[0][i] = '0; plane_v[1][i] = '0;
    end

    // results at reset settings: zero height, plus and minus amplitude
    zero_o = '{16'sd0, 8'd40, 8'd80, 8'd180, 1'b0};
    raft_o = '{-16'sd1638, 8'd56, 8'd112, 8'd210, 1'b0};
    dist_o = '{16'sd1638, 8'd24, 8'd49, 8'd151, 1'b0};
    none_o = '0;
    rows = '{
      '{'{1'b0, 1'b0, 1'b0, 16'h0000}, 1'b1, zero_o},
      '{'{1'b0, 1'b1, 1'b0, 16'h1234}, 1'b1, raft_o},
      '{'{1'b1, 1'b0, 1'b0, 16'hffff}, 1'b1, zero_o},
      '{'{1'b0, 1'b0, 1'b1, 16'h0001}, 1'b1, dist_o},
      '{'{1'b1, 1'b1, 1'b1, 16'hffff}, 1'b1, raft_o},
      '{'{1'b1, 1'b0, 1'b1, 16'h8000}, 1'b1, zero_o},
      '{'{1'b1, 1'b1, 1'b0, 16'h0000}, 1'b1, raft_o},
      '{'{1'b0, 1'b1, 1'b1, 16'h5555}, 1'b1, raft_o},
      '{'{1'b0, 1'b0, 1'b0, 16'hffff}, 1'b1, zero_o},
      '{'{1'b0, 1'b0, 1'b1, 16'haaaa}, 1'b0, none_o},
      '{'{1'b0, 1'b0, 1'b0, 16'h8000}, 1'b0, none_o},
      '{'{1'b0, 1'b1, 1'b0, 16'h0001}, 1'b0, none_o},
      '{'{1'b0, 1'b0, 1'b0, 16'h0001}, 1'b0, none_o},
      '{'{1'b1, 1'b0, 1'b0, 16'h7fff}, 1'b0, none_o},
      '{'{1'b0, 1'b0, 1'b0, 16'hffff}, 1'b0, none_o}
    };

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (rows[i]) push_cell(rows[i].req, rows[i].typed, rows[i].want);

    // random cells under several register settings
    cfg_sets = '{
      '{16'd1023, 16'd65535, 16'd4095, 16'd255},
      '{16'd0, 16'd0, 16'd0, 16'd0},
      '{16'd150, 16'd8520, 16'd1638, 16'd1},
      '{16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom)},
      '{16'($urandom_range(0, 1023)), 16'($urandom), 16'($urandom_range(0, 4095)),
        16'($urandom_range(1, 255))}
    };
    for (int ph = 0; ph < 5; ph++) begin
      set_regs(cfg_sets[ph][0], cfg_sets[ph][1], cfg_sets[ph][2], cfg_sets[ph][3]);
      calm = (ph == 2);
      for (int i = 0; i < 337; i++) push_cell(rand_cell(75), 1'b0, none_o);
      calm = 1'b0;
    end

    in_valid_i <= 1'b0;
    wait (pending_q.size() == 0);
    repeat (Settle) @(posedge clk_i);
    if (err_cnt == 0 && pending_q.size() == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

`default_nettype wire
